// ===== sv/aging_mac_dedup_table_assert.svh =====
// ----------------------------------------------------------------------------
// aging_mac_dedup_table_assert.svh
// assertion macros for the aging mac dedup table
// ----------------------------------------------------------------------------
`ifndef AGING_MAC_DEDUP_TABLE_ASSERT_SVH
`define AGING_MAC_DEDUP_TABLE_ASSERT_SVH

`ifndef SYNTH
`define AMDT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define AMDT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AMDT_ASSERT(name, prop)
`define AMDT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== sv/amdt_pkg.sv =====
// ----------------------------------------------------------------------------
// amdt_pkg
// shared types and constants of the aging mac dedup table
// ----------------------------------------------------------------------------
package amdt_pkg;

  localparam int unsigned MAC_W         = 48;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned TIMEOUT_W     = 16;
  localparam int unsigned SLOT_W        = 7;
  localparam int unsigned USED_W        = 8;
  localparam int unsigned VERDICT_W     = 2;
  localparam int unsigned TABLE_ENTRIES_DEF = 128;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_DUPLICATE = 2'd0,
    VERDICT_APPENDED  = 2'd1,
    VERDICT_REFRESHED = 2'd2,
    VERDICT_REPLACED  = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DECIDE = 2'd2
  } state_e;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] seen;
  } entry_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] now;
  } sighting_t;

  typedef struct packed {
    verdict_e          verdict;
    logic [SLOT_W-1:0] slot;
    logic [USED_W-1:0] used;
  } result_t;

endpackage

// ===== sv/amdt_ram.sv =====
// ----------------------------------------------------------------------------
// amdt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module amdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/amdt_fifo.sv =====
// ----------------------------------------------------------------------------
// amdt_fifo
// small register queue used for the sighting and result channels
// ----------------------------------------------------------------------------
module amdt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/amdt_engine.sv =====
// ----------------------------------------------------------------------------
// amdt_engine
// back end: scans the table one entry a cycle and applies the verdict
// ----------------------------------------------------------------------------
`include "aging_mac_dedup_table_assert.svh"

module amdt_engine #(
  parameter int unsigned TABLE_ENTRIES = amdt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [amdt_pkg::TIMEOUT_W-1:0] timeout_i,
  input  logic                           in_valid_i,
  input  amdt_pkg::sighting_t            in_word_i,
  output logic                           in_pop_o,
  input  logic                           res_full_i,
  output logic                           res_push_o,
  output amdt_pkg::result_t              res_word_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  amdt_pkg::state_e state_q, state_d;

  logic [amdt_pkg::MAC_W-1:0]  mac_q;
  logic [amdt_pkg::TIME_W-1:0] time_q;
  logic [amdt_pkg::TIME_W-1:0] seen_q;
  logic [CNT_W-1:0]            rd_idx_q;
  logic [CNT_W-1:0]            fill_q, fill_d;
  logic [IDX_W-1:0]            ptr_q, ptr_d;
  logic [IDX_W-1:0]            cmp_idx_q, slot_q, slot_sel;
  logic                        pend_q, hit_q;

  logic                        ram_re, ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  amdt_pkg::entry_t            ram_wdata, ram_rdata;

  logic                        hit_now, scan_done, has_room, dup, start;
  logic [amdt_pkg::TIME_W-1:0] age;
  amdt_pkg::verdict_e          verdict;
  logic [31:0]                 slot_ext, used_ext;

  amdt_ram #(
    .WIDTH ($bits(amdt_pkg::entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign start     = (state_q == amdt_pkg::ST_IDLE) && in_valid_i && !res_full_i;
  assign hit_now   = (state_q == amdt_pkg::ST_SCAN) && pend_q && (ram_rdata.mac == mac_q);
  assign scan_done = !pend_q && (rd_idx_q == fill_q);
  assign has_room  = (fill_q < CNT_W'(TABLE_ENTRIES));
  assign age       = time_q - seen_q;
  assign dup       = hit_q && (age < amdt_pkg::TIME_W'(timeout_i));

  always_comb begin
    verdict  = amdt_pkg::VERDICT_DUPLICATE;
    slot_sel = slot_q;
    fill_d   = fill_q;
    ptr_d    = ptr_q;
    if (hit_q) begin
      verdict = dup ? amdt_pkg::VERDICT_DUPLICATE : amdt_pkg::VERDICT_REFRESHED;
    end else if (has_room) begin
      verdict  = amdt_pkg::VERDICT_APPENDED;
      slot_sel = fill_q[IDX_W-1:0];
      fill_d   = fill_q + CNT_W'(1);
    end else begin
      verdict  = amdt_pkg::VERDICT_REPLACED;
      slot_sel = ptr_q;
      ptr_d    = (ptr_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : ptr_q + IDX_W'(1);
    end
  end

  assign slot_ext           = 32'(slot_sel);
  assign used_ext           = 32'(fill_d);
  assign res_word_o.verdict = verdict;
  assign res_word_o.slot    = slot_ext[amdt_pkg::SLOT_W-1:0];
  assign res_word_o.used    = used_ext[amdt_pkg::USED_W-1:0];
  assign ram_waddr          = slot_sel;
  assign ram_wdata.mac      = mac_q;
  assign ram_wdata.seen     = time_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      amdt_pkg::ST_IDLE: begin
        if (start) begin
          state_d = amdt_pkg::ST_SCAN;
        end
      end
      amdt_pkg::ST_SCAN: begin
        if (hit_now || scan_done) begin
          state_d = amdt_pkg::ST_DECIDE;
        end
      end
      amdt_pkg::ST_DECIDE: begin
        state_d = amdt_pkg::ST_IDLE;
      end
      default: begin
        state_d = amdt_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_pop_o   = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      amdt_pkg::ST_IDLE: begin
        in_pop_o = start;
      end
      amdt_pkg::ST_SCAN: begin
        ram_re = (rd_idx_q < fill_q) && !hit_now;
      end
      amdt_pkg::ST_DECIDE: begin
        ram_we     = !dup;
        res_push_o = 1'b1;
      end
      default: begin
        in_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= amdt_pkg::ST_IDLE;
      fill_q   <= '0;
      ptr_q    <= '0;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        rd_idx_q <= '0;
        pend_q   <= 1'b0;
        hit_q    <= 1'b0;
      end else if (state_q == amdt_pkg::ST_SCAN) begin
        pend_q <= ram_re;
        if (ram_re) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
        if (hit_now) begin
          hit_q <= 1'b1;
        end
      end
      if (res_push_o) begin
        fill_q <= fill_d;
        ptr_q  <= ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      mac_q  <= in_word_i.mac;
      time_q <= in_word_i.now;
    end
    if (ram_re) begin
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
    end
    if (hit_now) begin
      slot_q <= cmp_idx_q;
      seen_q <= ram_rdata.seen;
    end
  end

  `AMDT_ASSERT(a_fill_bound, fill_q <= CNT_W'(TABLE_ENTRIES))
  `AMDT_ASSERT(a_scan_bound, rd_idx_q <= fill_q)
  `AMDT_ASSERT(a_ptr_only_full, !$stable(ptr_q) |-> (fill_q == CNT_W'(TABLE_ENTRIES)))
  `AMDT_ASSERT(a_push_room, res_push_o |-> !res_full_i)
  `AMDT_ASSERT_NEXT(a_push_then_idle, res_push_o, state_q == amdt_pkg::ST_IDLE)

endmodule

// ===== sv/aging_mac_dedup_table.sv =====
// ----------------------------------------------------------------------------
// aging_mac_dedup_table
// de-duplicating table of station addresses with aging of last-seen times
// ----------------------------------------------------------------------------
// sightings enter through a queue: push with mac_address_i and
// time_seconds_i, taken when full is low. each sighting gives one result
// word (verdict_o, slot_index_o, entries_used_o) at the result queue, shown
// while empty is low and removed with pop.
// the back end pops one sighting, reads the table ram one entry a cycle
// until the first match or the end of the filled part, then writes back
// unless the sighting is a duplicate, and posts the result. the table
// ram has a single read port, so the scan reads one entry at a time,
// and the back end takes the next sighting only after it has posted
// the result. a sighting is also held off while the result queue is
// full, so a stalled receiver stops the back end and then the input
// queue fills and raises full. reset empties both queues and the table;
// no clearing pass is needed. timeout_seconds_i must be written with
// timeout_seconds_we_i while idle (not enforced here); it resets to 30.
// ----------------------------------------------------------------------------
module aging_mac_dedup_table #(
  parameter int unsigned TABLE_ENTRIES = amdt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [amdt_pkg::MAC_W-1:0]     mac_address_i,
  input  logic [amdt_pkg::TIME_W-1:0]    time_seconds_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [amdt_pkg::VERDICT_W-1:0] verdict_o,
  output logic [amdt_pkg::SLOT_W-1:0]    slot_index_o,
  output logic [amdt_pkg::USED_W-1:0]    entries_used_o,
  input  logic                           timeout_seconds_we_i,
  input  logic [amdt_pkg::TIMEOUT_W-1:0] timeout_seconds_i
);

  logic [amdt_pkg::TIMEOUT_W-1:0] timeout_q;
  amdt_pkg::sighting_t            in_word, head_word;
  amdt_pkg::result_t              res_word, out_word;
  logic                           in_empty, in_pop, res_full, res_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= amdt_pkg::TIMEOUT_RESET;
    end else if (timeout_seconds_we_i) begin
      timeout_q <= timeout_seconds_i;
    end
  end

  assign in_word.mac = mac_address_i;
  assign in_word.now = time_seconds_i;

  amdt_fifo #(
    .WIDTH ($bits(amdt_pkg::sighting_t)),
    .DEPTH (amdt_pkg::QUEUE_DEPTH)
  ) u_in_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .wdata_i (in_word),
    .pop_i   (in_pop),
    .empty_o (in_empty),
    .rdata_o (head_word)
  );

  amdt_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .timeout_i  (timeout_q),
    .in_valid_i (!in_empty),
    .in_word_i  (head_word),
    .in_pop_o   (in_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_word_o (res_word)
  );

  amdt_fifo #(
    .WIDTH ($bits(amdt_pkg::result_t)),
    .DEPTH (amdt_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_word),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_word)
  );

  assign verdict_o      = out_word.verdict;
  assign slot_index_o   = out_word.slot;
  assign entries_used_o = out_word.used;

endmodule
